### rtl/p2p420_pkg.sv
// Shared types and constants for the packed 4:4:4 to planar 4:2:0 converter.
package p2p420_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_ROWS_DEF  = 4096;
    localparam int OUTQ_DEPTH    = 4;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 9;
    localparam int ENT_W     = 2 * SUM_W;
    localparam int OFF_W     = 25;
    localparam int LW_W      = 13;
    localparam int PITCH_W   = 14;
    localparam int SROW_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_PITCH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 2'd3;

    localparam logic [LW_W-1:0]    LINE_WIDTH_RST = 13'd1920;
    localparam logic [PITCH_W-1:0] OUT_PITCH_RST  = 14'd1920;

    localparam logic FMT_I420 = 1'b0;
    localparam logic FMT_NV12 = 1'b1;

    localparam logic KIND_LUMA   = 1'b0;
    localparam logic KIND_CHROMA = 1'b1;

    // Everything one pixel produces: the luma word and an optional chroma word.
    typedef struct packed {
        logic [OFF_W-1:0] luma_off;
        logic [PIX_W-1:0] luma_val;
        logic             has_chroma;
        logic [OFF_W-1:0] chroma_off;
        logic [PIX_W-1:0] u_avg;
        logic [PIX_W-1:0] v_avg;
    } pix_result_t;

endpackage

### rtl/p2p420_line_buf.sv
// Line buffer of horizontal U/V pair sums, one write and one registered read port.
module p2p420_line_buf import p2p420_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF / 2,
    parameter int AW    = $clog2(MAX_WIDTH_DEF / 2)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [ENT_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [ENT_W-1:0] rd_data
);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/p2p420_out_queue.sv
// Result queue: one entry per pixel, drained as one or two output words.
module p2p420_out_queue import p2p420_pkg::*; #(
    parameter int DEPTH = OUTQ_DEPTH,
    parameter int CW    = $clog2(OUTQ_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pix_result_t      push_data,
    output logic [CW-1:0]    count,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             kind,
    output logic [OFF_W-1:0] offset,
    output logic [PIX_W-1:0] first_value,
    output logic [PIX_W-1:0] second_value,
    output logic             last
);

    localparam int PW = $clog2(DEPTH);

    pix_result_t     entries [DEPTH];
    logic [PW-1:0]   head_reg, head_next;
    logic [PW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            phase_reg, phase_next;
    pix_result_t     head;
    logic            pop;

    assign head         = entries[head_reg];
    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && result_ready && (phase_reg || !head.has_chroma);
    assign count        = count_reg;

    always_comb
    begin
        if (phase_reg)
        begin
            kind         = KIND_CHROMA;
            offset       = head.chroma_off;
            first_value  = head.u_avg;
            second_value = head.v_avg;
            last         = 1'b1;
        end
        else
        begin
            kind         = KIND_LUMA;
            offset       = head.luma_off;
            first_value  = head.luma_val;
            second_value = '0;
            last         = !head.has_chroma;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        if (pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        if (result_valid && result_ready)
        begin
            phase_next = !pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[tail_reg] <= push_data;
        end
    end

endmodule

### rtl/packed_yuv444_to_planar_yuv420.sv
// Packed 4:4:4 pixel stream to I420/NV12 luma and chroma words with byte offsets.
// Accepted pixels pass the stage 1 registers, then the result queue, before words are offered.
// Throughput: one pixel per cycle while the result queue has room; each odd-column pixel
// makes one line buffer access, and every pixel one stage pass. On odd rows each odd-column
// pixel yields two words, so the one-word-per-cycle output port backs those rows up.
// Reset: position counters and held chroma cleared, registers to defaults; line buffer not cleared.
module packed_yuv444_to_planar_yuv420 import p2p420_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  logic [PIX_W-1:0]      chroma_u,
    input  logic [PIX_W-1:0]      luma,
    input  logic [PIX_W-1:0]      chroma_v,
    input  logic                  strip_start,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  kind,
    output logic [OFF_W-1:0]      offset,
    output logic [PIX_W-1:0]      first_value,
    output logic [PIX_W-1:0]      second_value,
    output logic                  last
);

    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int RW         = $clog2(MAX_ROWS);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SW         = $clog2(LINE_DEPTH);
    localparam int IRW        = ((RW > SROW_W) ? RW : SROW_W) + 1;
    localparam int QCW        = $clog2(OUTQ_DEPTH + 1);
    localparam int MW         = IRW + PITCH_W;

    function automatic logic [RW-1:0] row_step(input logic [RW-1:0] rv);
        logic [RW:0] rp;
        begin
            rp = {1'b0, rv} + 1'b1;
            row_step = (rp == (RW + 1)'(MAX_ROWS)) ? '0 : rp[RW-1:0];
        end
    endfunction

    // configuration
    logic                fmt_reg;
    logic [LW_W-1:0]     line_width_reg;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [SROW_W-1:0]   start_row_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= FMT_I420;
            line_width_reg <= LINE_WIDTH_RST;
            pitch_reg      <= OUT_PITCH_RST;
            start_row_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OUT_FORMAT: fmt_reg        <= cfg_data[0];
                CFG_LINE_WIDTH: line_width_reg <= cfg_data[LW_W-1:0];
                CFG_OUT_PITCH:  pitch_reg      <= cfg_data[PITCH_W-1:0];
                CFG_START_ROW:  start_row_reg  <= cfg_data[SROW_W-1:0];
            endcase
        end
    end

    // effective width: clamped to [4, MAX_WIDTH], multiple of four
    logic [PITCH_W-1:0] lw_ext, lw_clamp;
    logic [WW-1:0]      eff_w;

    assign lw_ext = PITCH_W'(line_width_reg);

    always_comb
    begin
        priority if (lw_ext < PITCH_W'(4))
        begin
            lw_clamp = PITCH_W'(4);
        end
        else if (lw_ext > PITCH_W'(MAX_WIDTH))
        begin
            lw_clamp = PITCH_W'(MAX_WIDTH);
        end
        else
        begin
            lw_clamp = lw_ext;
        end
    end

    assign eff_w = WW'(lw_clamp & ~PITCH_W'(3));

    // position tracking
    logic [XW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [2*PIX_W-1:0] held_reg;
    logic [XW-1:0]    x;
    logic [RW-1:0]    r;
    logic [WW-1:0]    x_p1;
    logic [IRW-1:0]   img_row;
    logic             accept;
    logic [SUM_W-1:0] su, sv;
    logic             s1_valid_reg;
    logic [QCW:0]     pending;
    logic [QCW-1:0]   q_count;

    assign pending     = (QCW + 1)'(q_count) + (QCW + 1)'(s1_valid_reg);
    assign pixel_ready = (pending < (QCW + 1)'(OUTQ_DEPTH));
    assign accept      = pixel_valid && pixel_ready;

    always_comb
    begin
        if (strip_start)
        begin
            x = '0;
            r = '0;
        end
        else if (WW'(col_reg) >= eff_w)
        begin
            // width lowered mid-row: start a new row
            x = '0;
            r = row_step(row_reg);
        end
        else
        begin
            x = col_reg;
            r = row_reg;
        end
        x_p1 = WW'(x) + 1'b1;
        if (x_p1 >= eff_w)
        begin
            col_next = '0;
            row_next = row_step(r);
        end
        else
        begin
            col_next = x_p1[XW-1:0];
            row_next = r;
        end
    end

    assign img_row = IRW'({start_row_reg[SROW_W-1:1], 1'b0}) + IRW'(r);
    assign su      = {1'b0, held_reg[PIX_W-1:0]} + {1'b0, chroma_u};
    assign sv      = {1'b0, held_reg[2*PIX_W-1:PIX_W]} + {1'b0, chroma_v};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (!x[0])
            begin
                held_reg <= {chroma_v, chroma_u};
            end
        end
    end

    // line buffer: even rows write pair sums, odd rows read them back
    logic             lb_wr_en, lb_rd_en;
    logic [SW-1:0]    lb_addr;
    logic [ENT_W-1:0] lb_rd_data;

    assign lb_wr_en = accept && x[0] && !r[0];
    assign lb_rd_en = accept && x[0] && r[0];
    assign lb_addr  = SW'(x >> 1);

    p2p420_line_buf #(
        .DEPTH (LINE_DEPTH),
        .AW    (SW)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (lb_wr_en),
        .wr_addr (lb_addr),
        .wr_data ({sv, su}),
        .rd_en   (lb_rd_en),
        .rd_addr (lb_addr),
        .rd_data (lb_rd_data)
    );

    // stage 1: averages and offsets
    logic [XW-1:0]    s1_x_reg;
    logic [IRW-1:0]   s1_row_reg;
    logic [PIX_W-1:0] s1_y_reg;
    logic [SUM_W-1:0] s1_su_reg, s1_sv_reg;
    logic             s1_chroma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg      <= x;
            s1_row_reg    <= img_row;
            s1_y_reg      <= luma;
            s1_su_reg     <= su;
            s1_sv_reg     <= sv;
            s1_chroma_reg <= x[0] && r[0];
        end
    end

    logic [PITCH_W-1:0] luma_mult, chroma_mult;
    logic [MW-1:0]      luma_prod, chroma_prod;
    logic [OFF_W-1:0]   chroma_col;
    logic [SUM_W:0]     u_total, v_total;
    pix_result_t        s1_result;

    assign luma_mult   = (fmt_reg == FMT_NV12) ? pitch_reg : PITCH_W'(eff_w);
    assign chroma_mult = (fmt_reg == FMT_NV12) ? pitch_reg : PITCH_W'(eff_w >> 1);
    assign chroma_col  = (fmt_reg == FMT_NV12) ? (OFF_W'(s1_x_reg) - 1'b1)
                                               : OFF_W'(s1_x_reg >> 1);
    assign luma_prod   = MW'(s1_row_reg) * MW'(luma_mult);
    assign chroma_prod = MW'(s1_row_reg >> 1) * MW'(chroma_mult);
    assign u_total     = {1'b0, s1_su_reg} + {1'b0, lb_rd_data[SUM_W-1:0]};
    assign v_total     = {1'b0, s1_sv_reg} + {1'b0, lb_rd_data[ENT_W-1:SUM_W]};

    always_comb
    begin
        s1_result.luma_off   = OFF_W'(luma_prod) + OFF_W'(s1_x_reg);
        s1_result.luma_val   = s1_y_reg;
        s1_result.has_chroma = s1_chroma_reg;
        s1_result.chroma_off = OFF_W'(chroma_prod) + chroma_col;
        s1_result.u_avg      = u_total[SUM_W:2];
        s1_result.v_avg      = v_total[SUM_W:2];
    end

    p2p420_out_queue #(
        .DEPTH (OUTQ_DEPTH),
        .CW    (QCW)
    ) u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s1_valid_reg),
        .push_data    (s1_result),
        .count        (q_count),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .offset       (offset),
        .first_value  (first_value),
        .second_value (second_value),
        .last         (last)
    );

endmodule

### tb/sv/yuv420_checker.sv
// Watches the converter's ports, predicts every output word and compares it.
module yuv420_checker import p2p420_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    input  logic                  pixel_ready,
    input  logic [PIX_W-1:0]      chroma_u,
    input  logic [PIX_W-1:0]      luma,
    input  logic [PIX_W-1:0]      chroma_v,
    input  logic                  strip_start,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic                  kind,
    input  logic [OFF_W-1:0]      offset,
    input  logic [PIX_W-1:0]      first_value,
    input  logic [PIX_W-1:0]      second_value,
    input  logic                  last,
    output int                    errors,
    output int                    pending,
    output int                    words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = MAX_WIDTH_DEF / 2;

    typedef struct packed {
        logic             kind;
        logic [OFF_W-1:0] offset;
        logic [PIX_W-1:0] first_value;
        logic [PIX_W-1:0] second_value;
        logic             last;
    } word_t;

    word_t expected_words[$];

    // register copies
    logic               fmt;
    logic [LW_W-1:0]    width_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [SROW_W-1:0]  srow_reg;

    // position and chroma history
    logic [11:0]        col_pos;
    logic [11:0]        row_pos;
    logic [PIX_W-1:0]   held_u;
    logic [PIX_W-1:0]   held_v;
    logic [ENT_W-1:0]   pair_sums [SLOTS];

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < 4)
            w = 4;
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        return w & ~32'd3;
    endfunction

    // Expected words for one accepted pixel; updates position and line state.
    function automatic void convert_pixel(logic [PIX_W-1:0] u, logic [PIX_W-1:0] y,
                                          logic [PIX_W-1:0] v, logic first_pix);
        int unsigned w;
        int unsigned x;
        int unsigned r;
        int unsigned img_row;
        int unsigned slot;
        int unsigned su;
        int unsigned sv;
        int unsigned au;
        int unsigned av;
        longint unsigned base;
        longint unsigned off;
        word_t wd;
        w = active_width();
        x = col_pos;
        r = row_pos;
        if (first_pix)
        begin
            x = 0;
            r = 0;
        end
        else if (x >= w)
        begin
            // width dropped below the current column: new row
            x = 0;
            r = (r + 1) % MAX_ROWS_DEF;
        end
        img_row = (srow_reg & ~12'd1) + r;
        slot = (x >> 1) % SLOTS;

        base = img_row;
        if (fmt == FMT_NV12)
            off = base * pitch_reg + x;
        else
            off = base * w + x;
        wd.kind = KIND_LUMA;
        wd.offset = off[OFF_W-1:0];
        wd.first_value = y;
        wd.second_value = '0;
        wd.last = 1'b1;

        if (x[0] == 1'b0)
        begin
            held_u = u;
            held_v = v;
            expected_words.push_back(wd);
        end
        else
        begin
            su = held_u + u;
            sv = held_v + v;
            if (r[0] == 1'b0)
            begin
                pair_sums[slot] = {sv[8:0], su[8:0]};
                expected_words.push_back(wd);
            end
            else
            begin
                au = (su + pair_sums[slot][8:0]) >> 2;
                av = (sv + pair_sums[slot][17:9]) >> 2;
                wd.last = 1'b0;
                expected_words.push_back(wd);
                base = img_row >> 1;
                if (fmt == FMT_NV12)
                    off = base * pitch_reg + (x - 1);
                else
                    off = base * (w >> 1) + (x >> 1);
                wd.kind = KIND_CHROMA;
                wd.offset = off[OFF_W-1:0];
                wd.first_value = au[7:0];
                wd.second_value = av[7:0];
                wd.last = 1'b1;
                expected_words.push_back(wd);
            end
        end

        x = x + 1;
        if (x >= w)
        begin
            x = 0;
            r = (r + 1) % MAX_ROWS_DEF;
        end
        col_pos = x[11:0];
        row_pos = r[11:0];
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        word_t want;
        if (!rst_n)
        begin
            fmt = FMT_I420;
            width_reg = LINE_WIDTH_RST;
            pitch_reg = OUT_PITCH_RST;
            srow_reg = '0;
            col_pos = '0;
            row_pos = '0;
            held_u = '0;
            held_v = '0;
            expected_words.delete();
            errors = 0;
            words = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OUT_FORMAT: fmt = cfg_data[0];
                    CFG_LINE_WIDTH: width_reg = cfg_data[LW_W-1:0];
                    CFG_OUT_PITCH:  pitch_reg = cfg_data[PITCH_W-1:0];
                    CFG_START_ROW:  srow_reg = cfg_data[SROW_W-1:0];
                    default: ;
                endcase
            end
            if (pixel_valid && pixel_ready)
                convert_pixel(chroma_u, luma, chroma_v, strip_start);
            if (result_valid && result_ready)
            begin
                words = words + 1;
                if (expected_words.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected word, expected none, actual kind %0d offset %0d",
                             $time, kind, offset);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("offset", want.offset, offset);
                    check_field("first_value", want.first_value, first_value);
                    check_field("second_value", want.second_value, second_value);
                    check_field("last", want.last, last);
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

### tb/sv/testbench.sv
// Top of the converter testbench: clock, reset, pixel and register stimulus, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import p2p420_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pixel_valid;
    logic                  pixel_ready;
    logic [PIX_W-1:0]      chroma_u;
    logic [PIX_W-1:0]      luma;
    logic [PIX_W-1:0]      chroma_v;
    logic                  strip_start;
    logic                  result_valid;
    logic                  result_ready;
    logic                  kind;
    logic [OFF_W-1:0]      offset;
    logic [PIX_W-1:0]      first_value;
    logic [PIX_W-1:0]      second_value;
    logic                  last;

    int errors;
    int pending;
    int words;
    int pixels_sent;
    bit idle_on;
    bit long_hold;

    packed_yuv444_to_planar_yuv420 i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
        .chroma_u(chroma_u), .luma(luma), .chroma_v(chroma_v), .strip_start(strip_start),
        .result_valid(result_valid), .result_ready(result_ready),
        .kind(kind), .offset(offset), .first_value(first_value),
        .second_value(second_value), .last(last)
    );

    yuv420_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
        .chroma_u(chroma_u), .luma(luma), .chroma_v(chroma_v), .strip_start(strip_start),
        .result_valid(result_valid), .result_ready(result_ready),
        .kind(kind), .offset(offset), .first_value(first_value),
        .second_value(second_value), .last(last),
        .errors(errors), .pending(pending), .words(words)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off to back the block up.
    initial
    begin : sink
        int n;
        bit hold_done;
        hold_done = 1'b0;
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
                result_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                result_ready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(negedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] rand_byte();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Leaves valid high after the word is taken; the next call or drain moves it.
    task automatic send_pixel(logic [PIX_W-1:0] u, logic [PIX_W-1:0] y,
                              logic [PIX_W-1:0] v, logic first_pix);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        chroma_u <= u;
        luma <= y;
        chroma_v <= v;
        strip_start <= first_pix;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        @(negedge clk);
        pixels_sent++;
    endtask

    task automatic feed_strip(int n, bit with_start, bit noise);
        bit ss;
        for (int i = 0; i < n; i++)
        begin
            ss = (i == 0) ? with_start : (noise && $urandom_range(0, 49) == 0);
            send_pixel(rand_byte(), rand_byte(), rand_byte(), ss);
        end
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic fmt, int lw, int pitch, int srow);
        write_reg(CFG_OUT_FORMAT, CFG_DATA_W'(fmt));
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(lw));
        write_reg(CFG_OUT_PITCH, CFG_DATA_W'(pitch));
        write_reg(CFG_START_ROW, CFG_DATA_W'(srow));
    endtask

    initial
    begin : stimulus
        int left;
        int phase;
        int lw;
        int ew;
        int n;
        int sel;
        logic fmt;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_valid = 1'b0;
        chroma_u = '0;
        luma = '0;
        chroma_v = '0;
        strip_start = 1'b0;
        idle_on = 1'b1;
        long_hold = 1'b0;
        pixels_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // 4-wide I420 strip with extreme samples
        set_config(FMT_I420, 4, 4, 0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h80, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h7F, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h01, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFE, 8'hFF, 1'b0);
        drain();

        // NV12, width below minimum, pitch below 4, odd start row
        set_config(FMT_NV12, 2, 1, 3);
        feed_strip(8, 1'b1, 1'b0);
        drain();

        // width lowered mid-row: next pixel opens the odd row
        set_config(FMT_I420, 16, 16, 0);
        feed_strip(11, 1'b1, 1'b0);
        drain();
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(8));
        feed_strip(8, 1'b0, 1'b0);
        drain();

        // last image rows with the widest pitch: luma and chroma offsets wrap
        idle_on = 1'b0;
        set_config(FMT_NV12, 4, 16383, 4095);
        feed_strip(24, 1'b1, 1'b0);
        drain();
        idle_on = 1'b1;

        left = 790;
        phase = 0;
        while (left > 0)
        begin
            fmt = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 9);
            if (sel < 7)
                lw = 4 * $urandom_range(1, 12);
            else if (sel < 9)
                lw = $urandom_range(0, 60);
            else
                lw = $urandom_range(MAX_WIDTH_DEF + 1, 8191);
            ew = (lw < 4) ? 4 : (lw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : lw;
            ew = ew & ~3;
            if (ew > 64)
                n = $urandom_range(20, 60);
            else
                n = ew * $urandom_range(2, 6) + $urandom_range(0, ew - 1);
            if (n > left)
                n = left;
            set_config(fmt, lw,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(4, 16383),
                       $urandom_range(0, 4095));
            if (phase == 2)
                long_hold = 1'b1;
            if (left < 150)
                idle_on = 1'b0;
            feed_strip(n, 1'b1, 1'b1);
            drain();
            left -= n;
            phase++;
        end

        $display("Fed %0d pixels and checked %0d words in %0d random strips plus directed ones,",
                 pixels_sent, words, phase);
        $display("covering I420 and NV12, widths 4 to 4096, small pitches and offset wrap.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### packed_yuv444_to_planar_yuv420.f
rtl/p2p420_pkg.sv
rtl/p2p420_line_buf.sv
rtl/p2p420_out_queue.sv
rtl/packed_yuv444_to_planar_yuv420.sv
tb/sv/yuv420_checker.sv
tb/sv/testbench.sv
